// File: rtl/jfls_pkg.sv
`default_nettype none
package jfls_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4194304;

  localparam int unsigned SIZE_W = 23;
  localparam int unsigned STATUS_W = 2;
  // Holds positions up to MAX_FRAME_BYTES - 1 plus headroom for the +1.
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES) + 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_FRAME_BYTES - 1);

  localparam logic [7:0] BYTE_PREFIX = 8'hFF;
  localparam logic [7:0] BYTE_STUFF  = 8'h00;
  localparam logic [7:0] CODE_TEM    = 8'h01;
  localparam logic [7:0] CODE_RST0   = 8'hD0;
  localparam logic [7:0] CODE_RST7   = 8'hD7;
  localparam logic [7:0] CODE_SOI    = 8'hD8;
  localparam logic [7:0] CODE_EOI    = 8'hD9;
  localparam logic [7:0] CODE_SOS    = 8'hDA;

  typedef enum logic [STATUS_W-1:0] {
    ST_EOI       = 2'd0,
    ST_SHORT     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4,
    PH_SCAN   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] frame_size;
    status_t           status;
  } verdict_t;

  // Phase that follows a marker code byte.
  function automatic phase_t code_phase(input logic [7:0] code);
    if (code inside {CODE_TEM, [CODE_RST0:CODE_SOI], CODE_EOI}) begin
      return PH_PREFIX;
    end else if (code == CODE_SOS) begin
      return PH_SCAN;
    end else begin
      return PH_LEN_HI;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/jfls_parser.sv
`default_nettype none
module jfls_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire jfls_pkg::byte_item_t item,
  output jfls_pkg::verdict_t       verdict
);
  import jfls_pkg::*;

  phase_t            parse_phase, parse_phase_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [15:0]       skip_remaining, skip_remaining_next;
  logic [7:0]        length_high, length_high_next;
  logic              scan_saw_prefix, scan_saw_prefix_next;
  logic              verdict_given, verdict_given_next;

  // Effective state: a first byte restarts the parser before it is handled.
  phase_t            ph;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_inc;
  logic [15:0]       skip_cur;
  logic [15:0]       skip_dec;
  logic [7:0]        lh_cur;
  logic              saw_cur;
  logic              done_cur;
  logic [15:0]       seg_len;
  logic              at_end;
  logic              eoi_hit;
  logic              bad_hit;
  logic [7:0]        b;

  always_comb begin
    b        = item.data_byte;
    ph       = item.first_byte ? PH_PREFIX : parse_phase;
    pos      = item.first_byte ? '0 : byte_position;
    skip_cur = item.first_byte ? '0 : skip_remaining;
    lh_cur   = item.first_byte ? '0 : length_high;
    saw_cur  = item.first_byte ? 1'b0 : scan_saw_prefix;
    done_cur = item.first_byte ? 1'b0 : verdict_given;
    pos_inc  = pos + POS_W'(1);
    seg_len  = {lh_cur, b};
    skip_dec = skip_cur - 16'((skip_cur != '0) ? 1 : 0);
    at_end   = item.last_byte || (pos >= LAST_POS);

    parse_phase_next     = ph;
    byte_position_next   = pos_inc;
    skip_remaining_next  = skip_cur;
    length_high_next     = lh_cur;
    scan_saw_prefix_next = saw_cur;
    eoi_hit              = 1'b0;
    bad_hit              = 1'b0;

    case (ph)
      PH_PREFIX: begin
        if (b != BYTE_PREFIX) begin
          bad_hit = 1'b1;
        end else begin
          parse_phase_next = PH_CODE;
        end
      end
      PH_CODE: begin
        parse_phase_next     = code_phase(b);
        eoi_hit              = (b == CODE_EOI);
        scan_saw_prefix_next = 1'b0;
      end
      PH_LEN_HI: begin
        length_high_next = b;
        parse_phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < 16'd2) begin
          bad_hit = 1'b1;
        end else begin
          skip_remaining_next = seg_len - 16'd2;
          parse_phase_next    = (seg_len != 16'd2) ? PH_SKIP : PH_PREFIX;
        end
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == '0) begin
          parse_phase_next = PH_PREFIX;
        end
      end
      PH_SCAN: begin
        if (saw_cur) begin
          scan_saw_prefix_next = 1'b0;
          if (!(b == BYTE_STUFF || (b inside {[CODE_RST0:CODE_RST7]}))) begin
            parse_phase_next = code_phase(b);
            eoi_hit          = (b == CODE_EOI);
          end
        end else if (b == BYTE_PREFIX) begin
          scan_saw_prefix_next = 1'b1;
        end
      end
      default: begin
        parse_phase_next = PH_PREFIX;
        bad_hit          = 1'b1;
      end
    endcase

    verdict.valid      = !done_cur && (eoi_hit || bad_hit || at_end);
    verdict.frame_size = eoi_hit ? SIZE_W'(pos_inc) : '0;
    if (bad_hit) begin
      verdict.status = ST_MALFORMED;
    end else if (eoi_hit) begin
      verdict.status = ST_EOI;
    end else begin
      verdict.status = ST_SHORT;
    end
    verdict_given_next = done_cur || verdict.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_PREFIX;
      byte_position   <= '0;
      skip_remaining  <= '0;
      length_high     <= '0;
      scan_saw_prefix <= 1'b0;
      verdict_given   <= 1'b0;
    end else if (step) begin
      if (item.first_byte || !verdict_given) begin
        parse_phase     <= parse_phase_next;
        byte_position   <= byte_position_next;
        skip_remaining  <= skip_remaining_next;
        length_high     <= length_high_next;
        scan_saw_prefix <= scan_saw_prefix_next;
      end
      verdict_given <= verdict_given_next;
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    !verdict_given |-> byte_position <= LAST_POS)
    else $error("byte position passed capacity without a verdict");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (verdict_given && !(step && item.first_byte)) |=> verdict_given)
    else $error("verdict flag dropped without a new frame");

  a_no_second: assert property (@(posedge clk) disable iff (rst)
    (verdict_given && !item.first_byte) |-> !verdict.valid)
    else $error("second verdict in one frame");

endmodule
`default_nettype wire

// File: rtl/jpeg_frame_length_scanner_top.sv
`default_nettype none
// JPEG frame length scanner: walks marker segments byte by byte, one verdict per frame.
// Path: a byte is accepted into the input register, the parser judges it combinationally,
// and its verdict is written to the result register, which raises out_valid.
// Throughput: 1 byte per cycle unless stalled (below); parser state updates once per byte.
// A waiting result stalls input only when the next byte also yields a result.
// Reset (rst, synchronous, active high): empties both registers, parser expects 0xFF.
module jpeg_frame_length_scanner_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          first_byte,
  input  wire logic                          last_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [jfls_pkg::SIZE_W-1:0]        frame_size,
  output logic [jfls_pkg::STATUS_W-1:0]      status
);
  import jfls_pkg::*;

  // Input register: one byte item waiting for the parser.
  logic       in_reg_valid;
  byte_item_t in_reg;

  // Verdict computed for the byte in the input register.
  verdict_t   verdict;

  // Result register.
  logic [SIZE_W-1:0] res_size;
  status_t           res_status;

  // The held byte moves on when its result (if any) has a free slot.
  logic advance;

  assign advance  = in_reg_valid && (!out_valid || out_ready || !verdict.valid);
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg.data_byte  <= data_byte;
      in_reg.first_byte <= first_byte;
      in_reg.last_byte  <= last_byte;
    end
  end

  jfls_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_reg),
    .verdict (verdict)
  );

  // A fresh verdict can only land when the slot is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && verdict.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && verdict.valid) begin
      res_size   <= verdict.frame_size;
      res_status <= verdict.status;
    end
  end

  assign frame_size = res_size;
  assign status     = res_status;

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_EOI || status == ST_SHORT || status == ST_MALFORMED))
    else $error("illegal status code on output");

  a_size_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_EOI) |-> frame_size == '0)
    else $error("nonzero frame size with error status");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(advance && verdict.valid))
    else $error("pending result overwritten");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_reg_valid && out_valid && verdict.valid))
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
